[hw/rtl/serial_disk_drive_responder_top_macros.svh]
// Assertion helpers used by the RTL controller (sddr_ctrl).
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef SERIAL_DISK_DRIVE_RESPONDER_TOP_MACROS_SVH
`define SERIAL_DISK_DRIVE_RESPONDER_TOP_MACROS_SVH

// Same-cycle implication.
`define SDDR_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("implication check failed");

// Next-cycle implication.
`define SDDR_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle check failed");

`endif

[hw/rtl/sddr_pkg.sv]
`default_nettype none
package sddr_pkg;

    localparam int STORE_BYTES  = 65536;
    localparam int SECTOR_BYTES = 128;
    localparam int HEADER_BYTES = 16;
    localparam int ADDR_W       = $clog2(STORE_BYTES);
    localparam int BLOCKS       = STORE_BYTES / SECTOR_BYTES;
    localparam int BLK_W        = $clog2(BLOCKS) + 1;
    localparam int CNT_W        = ADDR_W + 1;
    localparam int SEC_W        = $clog2(SECTOR_BYTES);
    localparam int RANGE_W      = 26;
    localparam int REM_STATUS   = 6;
    localparam int REM_READ     = SECTOR_BYTES + 2;
    localparam int REM_WRITE    = SECTOR_BYTES + 1;
    localparam int STATUS_LEN   = 4;

    localparam logic [7:0] DEVICE_ID_RESET = 8'd49;
    localparam logic [2:0] ADDR_DEVICE_ID  = 3'd0;

    localparam logic [7:0] CMD_READ   = 8'h52;
    localparam logic [7:0] CMD_WRITE  = 8'h50;
    localparam logic [7:0] CMD_STATUS = 8'h53;
    localparam logic [7:0] CMD_FMT_S  = 8'h21;
    localparam logic [7:0] CMD_FMT_E  = 8'h22;

    localparam logic [7:0] CH_ACK  = 8'h41;
    localparam logic [7:0] CH_NAK  = 8'h4E;
    localparam logic [7:0] CH_DONE = 8'h43;
    localparam logic [7:0] CH_ERR  = 8'h45;

    typedef enum logic [2:0] {
        PH_IDLE, PH_WAITCMD, PH_RXCMD, PH_EXEC,
        PH_SEND, PH_RXDATA, PH_WRITE, PH_FORMAT
    } phase_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_IDX_CLR, OP_RX_CMD, OP_EXEC, OP_SEND,
        OP_RX_DATA, OP_DATA_BAD, OP_FMT_STEP, OP_FMT_END
    } op_t;

    typedef enum logic [3:0] {
        SW_NONE, SW_CLEAR, SW_STATUS, SW_LOAD, SW_ZERO,
        SW_FILL, SW_STORE, SW_FORMAT, SW_READ1
    } sw_t;

    typedef enum logic [2:0] {
        TX_NONE, TX_N, TX_A, TX_C, TX_E, TX_F4, TX_SUM, TX_BUF
    } tx_t;

    typedef struct packed {
        op_t    op;
        sw_t    sw;
        logic   sw_start;
        tx_t    tx;
        logic   out_load;
        phase_t phase;
    } dp_cmd_t;

    typedef struct packed {
        logic       host;
        logic       cmd;
        logic       rxv;
        logic       txr;
        logic       sto;
        logic       idx_is5;
        logic       hdr_ok;
        logic       id_match;
        logic [7:0] code;
        logic       in_range;
        logic       rem_zero;
        logic       rem_one;
        logic       idx_zero;
        logic       dsum_ok;
        logic       fmt_done;
        logic       sw_busy;
        logic       out_free;
    } dp_st_t;

    // End-around-carry add.
    function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > 9'd255)
        begin
            s = s - 9'd255;
        end
        return s[7:0];
    endfunction

    function automatic logic [7:0] status_byte(input logic [1:0] i);
        logic [7:0] v;
        case (i)
            2'd0:    v = 8'h80;
            2'd1:    v = 8'hFF;
            2'd2:    v = 8'hE0;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] header_byte(input logic [3:0] i);
        logic [7:0] v;
        case (i)
            4'd0:    v = 8'h96;
            4'd1:    v = 8'h02;
            4'd3:    v = 8'h40;
            4'd4:    v = 8'h80;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/sddr_dp.sv]
`default_nettype none
module sddr_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [15:0]       s_tdata,
    input  wire logic              in_accept,
    input  wire logic [7:0]        device_id,
    input  wire sddr_pkg::dp_cmd_t cmd,
    input  wire logic              m_tready,
    output sddr_pkg::dp_st_t       st,
    output logic                   m_tvalid,
    output logic [15:0]            m_tdata
);
    import sddr_pkg::*;

    // latched item
    logic             host_reg, cmdl_reg, rxv_reg, txr_reg, sto_reg;
    logic [7:0]       rxb_reg;

    logic [7:0]       f_reg [0:4];
    logic [7:0]       f_next [0:4];
    logic [7:0]       idx_reg, idx_next;
    logic [7:0]       rem_reg, rem_next;
    logic [BLK_W-1:0] left_reg, left_next;
    logic [7:0]       ssum_reg, ssum_next;
    logic [7:0]       dsum_reg, dsum_next;

    // sweep engine
    sw_t              kind_reg, kind_next;
    logic             busy_reg, busy_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [ADDR_W-1:0] wptr_reg, wptr_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic             issue;

    logic             m_valid_reg, m_valid_next;
    logic [15:0]      m_data_reg, m_data_next;

    logic [7:0]       buf_mem [0:SECTOR_BYTES-1];
    logic [7:0]       store_mem [0:STORE_BYTES-1];
    logic [7:0]       buf_rd_reg, store_rd_reg;
    logic             buf_we, buf_re, st_we, st_re;
    logic [SEC_W-1:0] buf_wa, buf_ra;
    logic [7:0]       buf_wd, st_wd;
    logic [ADDR_W-1:0] st_wa, st_ra;

    logic [7:0]        hsum;
    logic [RANGE_W-1:0] sec_off;
    logic              in_range;
    logic [ADDR_W-1:0] sec_addr;
    logic [RANGE_W-1:0] blk_off;
    logic [BLK_W-1:0]  blk;
    logic [7:0]        idx_m1;
    logic [7:0]        txb;
    logic              txv;

    always_comb
    begin
        hsum     = eac_add(eac_add(eac_add(f_reg[0], f_reg[1]), f_reg[2]), f_reg[3]);
        sec_off  = (RANGE_W'({f_reg[3], f_reg[2]}) << SEC_W) + RANGE_W'(HEADER_BYTES);
        in_range = (sec_off + RANGE_W'(SECTOR_BYTES)) <= RANGE_W'(STORE_BYTES);
        sec_addr = sec_off[ADDR_W-1:0];
        blk      = BLK_W'(BLOCKS) - left_reg;
        blk_off  = RANGE_W'(blk) << SEC_W;
        idx_m1   = idx_reg - 8'd1;
    end

    always_comb
    begin
        st.host     = host_reg;
        st.cmd      = cmdl_reg;
        st.rxv      = rxv_reg;
        st.txr      = txr_reg;
        st.sto      = sto_reg;
        st.idx_is5  = (idx_reg == 8'd5);
        st.hdr_ok   = (hsum == f_reg[4]);
        st.id_match = (f_reg[0] == device_id);
        st.code     = f_reg[1];
        st.in_range = in_range;
        st.rem_zero = (rem_reg == 8'd0);
        st.rem_one  = (rem_reg == 8'd1);
        st.idx_zero = (idx_reg == 8'd0);
        st.dsum_ok  = (dsum_reg == rxb_reg);
        st.fmt_done = (left_reg == '0);
        st.sw_busy  = busy_reg;
        st.out_free = !m_valid_reg || m_tready;
    end

    // protocol registers
    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            f_next[i] = f_reg[i];
        end
        idx_next  = idx_reg;
        rem_next  = rem_reg;
        left_next = left_reg;
        ssum_next = ssum_reg;
        dsum_next = dsum_reg;
        case (cmd.op)
            OP_IDX_CLR:
            begin
                idx_next = 8'd0;
            end
            OP_RX_CMD:
            begin
                if (idx_reg < 8'd5)
                begin
                    f_next[idx_reg[2:0]] = rxb_reg;
                end
                if (idx_reg <= 8'd5)
                begin
                    idx_next = idx_reg + 8'd1;
                end
            end
            OP_EXEC:
            begin
                idx_next  = 8'd0;
                ssum_next = 8'd0;
                dsum_next = 8'd0;
                f_next[4] = CH_NAK;
                rem_next  = 8'd1;
                case (f_reg[1])
                    CMD_STATUS:
                    begin
                        f_next[4] = CH_DONE;
                        rem_next  = 8'(REM_STATUS);
                    end
                    CMD_READ:
                    begin
                        f_next[4] = in_range ? CH_DONE : CH_ERR;
                        rem_next  = 8'(REM_READ);
                    end
                    CMD_WRITE:
                    begin
                        rem_next = 8'(REM_WRITE);
                    end
                    CMD_FMT_S, CMD_FMT_E:
                    begin
                        left_next = BLK_W'(BLOCKS);
                    end
                    default:
                    begin
                        rem_next = 8'd1;
                    end
                endcase
            end
            OP_SEND:
            begin
                idx_next = idx_reg + 8'd1;
                rem_next = rem_reg - 8'd1;
            end
            OP_RX_DATA:
            begin
                idx_next  = idx_reg + 8'd1;
                rem_next  = rem_reg - 8'd1;
                dsum_next = eac_add(dsum_reg, rxb_reg);
            end
            OP_DATA_BAD:
            begin
                f_next[4] = CH_ERR;
                idx_next  = 8'd0;
                rem_next  = 8'd1;
                ssum_next = 8'd0;
            end
            OP_FMT_STEP:
            begin
                left_next = left_reg - BLK_W'(1);
            end
            OP_FMT_END:
            begin
                f_next[4] = CH_DONE;
                idx_next  = 8'd0;
                rem_next  = 8'(REM_READ);
                ssum_next = 8'd0;
            end
            default:
            begin
            end
        endcase
        // running sum of streamed data bytes
        if (cmd.out_load && cmd.tx == TX_BUF)
        begin
            ssum_next = eac_add(ssum_reg, buf_rd_reg);
        end
    end

    // sweep sequencing: read at cnt, write in the following cycle at wptr
    always_comb
    begin
        issue     = busy_reg && (cnt_reg < len_reg);
        kind_next = kind_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        len_next  = len_reg;
        base_next = base_reg;
        wptr_next = wptr_reg;
        pend_next = issue;
        if (cmd.sw_start)
        begin
            kind_next = cmd.sw;
            busy_next = 1'b1;
            cnt_next  = '0;
            pend_next = 1'b0;
            case (cmd.sw)
                SW_CLEAR:  len_next = CNT_W'(STORE_BYTES);
                SW_STATUS: len_next = CNT_W'(STATUS_LEN);
                SW_READ1:  len_next = CNT_W'(1);
                default:   len_next = CNT_W'(SECTOR_BYTES);
            endcase
            case (cmd.sw)
                SW_LOAD, SW_STORE: base_next = sec_addr;
                SW_FORMAT:         base_next = blk_off[ADDR_W-1:0];
                SW_READ1:          base_next = ADDR_W'(idx_m1[SEC_W-1:0]);
                default:           base_next = '0;
            endcase
        end
        else if (busy_reg)
        begin
            busy_next = issue;
            if (issue)
            begin
                cnt_next  = cnt_reg + CNT_W'(1);
                wptr_next = cnt_reg[ADDR_W-1:0];
            end
        end
    end

    // memory ports
    always_comb
    begin
        st_re  = issue && (kind_reg == SW_LOAD);
        st_ra  = base_reg + cnt_reg[ADDR_W-1:0];
        buf_re = issue && (kind_reg == SW_STORE || kind_reg == SW_READ1);
        buf_ra = (kind_reg == SW_READ1) ? base_reg[SEC_W-1:0] : cnt_reg[SEC_W-1:0];

        st_we = pend_reg && (kind_reg == SW_CLEAR || kind_reg == SW_STORE
                             || kind_reg == SW_FORMAT);
        st_wa = (kind_reg == SW_CLEAR) ? wptr_reg : base_reg + wptr_reg;
        st_wd = 8'hFF;
        if (kind_reg == SW_STORE)
        begin
            st_wd = buf_rd_reg;
        end
        else if (kind_reg == SW_FORMAT && base_reg == '0
                 && wptr_reg < ADDR_W'(HEADER_BYTES))
        begin
            st_wd = header_byte(wptr_reg[3:0]);
        end

        buf_we = 1'b0;
        buf_wa = wptr_reg[SEC_W-1:0];
        buf_wd = 8'hFF;
        if (cmd.op == OP_RX_DATA)
        begin
            buf_we = 1'b1;
            buf_wa = idx_reg[SEC_W-1:0];
            buf_wd = rxb_reg;
        end
        else if (pend_reg)
        begin
            case (kind_reg)
                SW_STATUS:
                begin
                    buf_we = 1'b1;
                    buf_wd = status_byte(wptr_reg[1:0]);
                end
                SW_LOAD:
                begin
                    buf_we = 1'b1;
                    buf_wd = store_rd_reg;
                end
                SW_ZERO:
                begin
                    buf_we = 1'b1;
                    buf_wd = 8'h00;
                end
                SW_FILL:
                begin
                    buf_we = 1'b1;
                    buf_wd = 8'hFF;
                end
                default:
                begin
                    buf_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_wa] <= st_wd;
        end
        if (st_re)
        begin
            store_rd_reg <= store_mem[st_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_wa] <= buf_wd;
        end
        if (buf_re)
        begin
            buf_rd_reg <= buf_mem[buf_ra];
        end
    end

    // result register
    always_comb
    begin
        txv = 1'b1;
        case (cmd.tx)
            TX_N:    txb = CH_NAK;
            TX_A:    txb = CH_ACK;
            TX_C:    txb = CH_DONE;
            TX_E:    txb = CH_ERR;
            TX_F4:   txb = f_reg[4];
            TX_SUM:  txb = ssum_reg;
            TX_BUF:  txb = buf_rd_reg;
            default:
            begin
                txb = 8'h00;
                txv = 1'b0;
            end
        endcase
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (cmd.out_load)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {4'b0000, cmd.phase, txb, txv};
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= 8'd0;
            rem_reg     <= 8'd0;
            left_reg    <= '0;
            kind_reg    <= SW_NONE;
            busy_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            cnt_reg     <= '0;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            rem_reg     <= rem_next;
            left_reg    <= left_next;
            kind_reg    <= kind_next;
            busy_reg    <= busy_next;
            pend_reg    <= pend_next;
            cnt_reg     <= cnt_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            host_reg <= s_tdata[0];
            cmdl_reg <= s_tdata[1];
            rxv_reg  <= s_tdata[2];
            rxb_reg  <= s_tdata[10:3];
            txr_reg  <= s_tdata[11];
            sto_reg  <= s_tdata[12];
        end
        for (int i = 0; i < 5; i++)
        begin
            f_reg[i] <= f_next[i];
        end
        ssum_reg   <= ssum_next;
        dsum_reg   <= dsum_next;
        base_reg   <= base_next;
        wptr_reg   <= wptr_next;
        m_data_reg <= m_data_next;
    end

endmodule
`default_nettype wire

[hw/rtl/sddr_ctrl.sv]
`default_nettype none
`include "serial_disk_drive_responder_top_macros.svh"
module sddr_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sddr_pkg::dp_st_t st,
    input  wire logic            in_accept,
    output logic                 s_tready,
    output sddr_pkg::dp_cmd_t    cmd
);
    import sddr_pkg::*;

    typedef enum logic [2:0] {
        C_CLEAR, C_CLR_WAIT, C_IDLE, C_DECIDE, C_SWEEP, C_OUT
    } cstate_t;

    cstate_t state_reg, state_next;
    phase_t  phase_reg, phase_next;
    tx_t     tx_reg, tx_next;

    op_t     d_op;
    sw_t     d_sw;
    tx_t     d_tx;
    phase_t  d_ph;

    // per-tick protocol decision
    always_comb
    begin
        d_op = OP_NONE;
        d_sw = SW_NONE;
        d_tx = TX_NONE;
        d_ph = phase_reg;
        if (!st.host)
        begin
            d_ph = PH_IDLE;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (!st.cmd)
                    begin
                        d_ph = PH_WAITCMD;
                    end
                end
                PH_WAITCMD:
                begin
                    if (st.cmd)
                    begin
                        d_op = OP_IDX_CLR;
                        d_ph = PH_RXCMD;
                    end
                end
                PH_RXCMD:
                begin
                    if (!st.cmd)
                    begin
                        if (st.idx_is5 && st.hdr_ok)
                        begin
                            d_ph = PH_EXEC;
                        end
                        else
                        begin
                            d_tx = TX_N;
                            d_ph = PH_IDLE;
                        end
                    end
                    else if (st.rxv)
                    begin
                        d_op = OP_RX_CMD;
                    end
                end
                PH_EXEC:
                begin
                    d_ph = PH_IDLE;
                    if (!st.cmd && st.id_match && st.sto)
                    begin
                        d_op = OP_EXEC;
                        d_ph = PH_SEND;
                        case (st.code)
                            CMD_STATUS:
                            begin
                                d_tx = TX_A;
                                d_sw = SW_STATUS;
                            end
                            CMD_READ:
                            begin
                                d_tx = TX_A;
                                d_sw = st.in_range ? SW_LOAD : SW_ZERO;
                            end
                            CMD_WRITE:
                            begin
                                d_tx = TX_A;
                                d_ph = PH_RXDATA;
                            end
                            CMD_FMT_S, CMD_FMT_E:
                            begin
                                d_tx = TX_A;
                                d_ph = PH_FORMAT;
                            end
                            default:
                            begin
                                d_tx = TX_NONE;
                            end
                        endcase
                    end
                end
                PH_SEND:
                begin
                    if (st.cmd)
                    begin
                        d_ph = PH_IDLE;
                    end
                    else if (st.txr)
                    begin
                        if (!st.rem_zero)
                        begin
                            d_op = OP_SEND;
                            if (st.idx_zero)
                            begin
                                d_tx = TX_F4;
                            end
                            else if (st.rem_one)
                            begin
                                d_tx = TX_SUM;
                            end
                            else
                            begin
                                d_tx = TX_BUF;
                                d_sw = SW_READ1;
                            end
                        end
                        else
                        begin
                            d_ph = PH_IDLE;
                        end
                    end
                end
                PH_RXDATA:
                begin
                    if (st.cmd)
                    begin
                        d_ph = PH_IDLE;
                    end
                    else if (st.rxv)
                    begin
                        if (!st.rem_zero && !st.rem_one)
                        begin
                            d_op = OP_RX_DATA;
                        end
                        else if (st.rem_one)
                        begin
                            if (st.dsum_ok)
                            begin
                                d_ph = PH_WRITE;
                            end
                            else
                            begin
                                d_op = OP_DATA_BAD;
                                d_ph = PH_SEND;
                            end
                        end
                        else
                        begin
                            d_ph = PH_IDLE;
                        end
                    end
                end
                PH_WRITE:
                begin
                    d_ph = PH_IDLE;
                    if (!st.cmd)
                    begin
                        if (st.in_range)
                        begin
                            d_tx = TX_C;
                            d_sw = SW_STORE;
                        end
                        else
                        begin
                            d_tx = TX_E;
                        end
                    end
                end
                default:
                begin
                    if (st.cmd)
                    begin
                        d_ph = PH_IDLE;
                    end
                    else if (!st.fmt_done)
                    begin
                        d_op = OP_FMT_STEP;
                        d_sw = SW_FORMAT;
                    end
                    else
                    begin
                        d_op = OP_FMT_END;
                        d_sw = SW_FILL;
                        d_ph = PH_SEND;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        tx_next      = tx_reg;
        cmd.op       = OP_NONE;
        cmd.sw       = SW_NONE;
        cmd.sw_start = 1'b0;
        cmd.tx       = tx_reg;
        cmd.out_load = 1'b0;
        cmd.phase    = phase_reg;
        case (state_reg)
            C_CLEAR:
            begin
                cmd.sw       = SW_CLEAR;
                cmd.sw_start = 1'b1;
                state_next   = C_CLR_WAIT;
            end
            C_CLR_WAIT:
            begin
                if (!st.sw_busy)
                begin
                    state_next = C_IDLE;
                end
            end
            C_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = C_DECIDE;
                end
            end
            C_DECIDE:
            begin
                cmd.op       = d_op;
                cmd.sw       = d_sw;
                cmd.sw_start = (d_sw != SW_NONE);
                phase_next   = d_ph;
                tx_next      = d_tx;
                state_next   = (d_sw != SW_NONE) ? C_SWEEP : C_OUT;
            end
            C_SWEEP:
            begin
                if (!st.sw_busy)
                begin
                    state_next = C_OUT;
                end
            end
            C_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == C_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_CLEAR;
            phase_reg <= PH_IDLE;
            tx_reg    <= TX_NONE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            tx_reg    <= tx_next;
        end
    end

    `SDDR_ASSERT_IMP(a_idle_no_sweep, state_reg == C_IDLE, !st.sw_busy)
    `SDDR_ASSERT_NXT(a_sweep_to_out, state_reg == C_SWEEP && !st.sw_busy, state_reg == C_OUT)
    `SDDR_ASSERT_IMP(a_load_when_free, cmd.out_load, st.out_free)

endmodule
`default_nettype wire

[hw/rtl/serial_disk_drive_responder_top.sv]
// Serial disk-drive responder: device side of a five-byte command frame bus.
// Input stream (s_*): one transfer per protocol tick, carrying the sampled
// host power, command line, received byte and transmitter readiness.
// Output stream (m_*): exactly one transfer per input tick, carrying whether
// a byte goes to the host, that byte, and the phase after the tick.
// APB port: register 0 is the device id (reset 49); pready is always high.
// Timing: a plain tick passes the input register, the decision state and
// the output register; the next transfer is taken once the controller idles.
// A tick that runs the copy engine (sector read, sector write, status or
// fill of the reply buffer, one 128-byte format block) moves one byte per
// cycle over one read and one write port of each memory, and its result
// follows once the copy is done. A reply data byte takes one extra buffer
// read. Ticks are handled one at a time.
// Reset: after rst_n rises the sector store is erased to 0xFF by a clearing
// pass; s_tready rises once that pass ends, APB writes still work meanwhile.
// Stall: the result sits in an output register; the next tick is taken while
// it waits, but its own result is held until m_tready drains the register.
`default_nettype none
module serial_disk_drive_responder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_tdata: host_ready[0], command_line[1], rx_valid[2], rx_byte[10:3],
    //          tx_ready[11], storage_present[12], zero[15:13]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,
    // m_tdata: tx_valid[0], tx_byte[8:1], phase[11:9], zero[15:12]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sddr_pkg::*;

    logic [7:0] id_reg, id_next;
    logic       in_accept;
    logic       cfg_wr;
    dp_cmd_t    cmd;
    dp_st_t     st;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign in_accept = s_tvalid && s_tready;

    // register file: only the device id is writable
    always_comb
    begin
        id_next = id_reg;
        if (cfg_wr && paddr == ADDR_DEVICE_ID)
        begin
            id_next = pwdata[7:0];
        end
        prdata = (paddr == ADDR_DEVICE_ID) ? {24'h0, id_reg} : 32'h0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg <= DEVICE_ID_RESET;
        end
        else
        begin
            id_reg <= id_next;
        end
    end

    sddr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .st        (st),
        .in_accept (in_accept),
        .s_tready  (s_tready),
        .cmd       (cmd)
    );

    sddr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .in_accept (in_accept),
        .device_id (id_reg),
        .cmd       (cmd),
        .m_tready  (m_tready),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire
